@@ rtl/core/jet_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types and constants for the Julia escape-time block.
// ----------------------------------------------------------------------------
package jet_pkg;

    localparam int DATA_W     = 32;
    localparam int PROD_W     = 64;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_BITS  = 28;
    localparam int MAX_ITER_DEF = 256;

    // 4.0 in unsigned Q8.56
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG = 2'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] start_real;
        logic signed [DATA_W-1:0] start_imag;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0] iteration_count;
        logic               inside_set;
    } t_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_status;

endpackage : jet_pkg
`default_nettype wire

@@ rtl/core/jet_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jet_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module jet_mul
    import jet_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic signed [DATA_W-1:0] i_a,
    input  wire logic signed [DATA_W-1:0] i_b,
    output logic signed [PROD_W-1:0]      o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule : jet_mul
`default_nettype wire

@@ rtl/core/jet_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jet_engine
// Sequencer and datapath for z = z*z + c over one shared multiplier.
// ----------------------------------------------------------------------------
module jet_engine
    import jet_pkg::*;
#(
    parameter int MAX_ITERATIONS = MAX_ITER_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire t_in                      i_point,
    input  wire logic signed [DATA_W-1:0] i_c_real,
    input  wire logic signed [DATA_W-1:0] i_c_imag,
    input  wire logic                     i_take,
    output t_eng_status                   o_status,
    output t_out                          o_result
);

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);
    localparam int EXT_W = 40;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITERATIONS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MRR,
        S_MII,
        S_MRI,
        S_CHK,
        S_UPD,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic signed [DATA_W-1:0] r_re;
    logic signed [DATA_W-1:0] r_im;
    logic signed [PROD_W-1:0] r_sq_re;
    logic signed [PROD_W-1:0] r_sq_im;
    logic signed [PROD_W-1:0] r_cross;
    logic signed [PROD_W-1:0] r_diff;
    logic [CNT_W-1:0]         r_count;

    logic signed [DATA_W-1:0] w_mul_a;
    logic signed [DATA_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0]        w_mag;
    logic                     w_escape;
    logic signed [EXT_W-1:0]  w_nre;
    logic signed [EXT_W-1:0]  w_nim;
    logic [CNT_W+COUNT_W-1:0] w_cnt_ext;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - EXT_W'(1);
        if (v > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

    jet_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    always_comb begin
        w_mul_a = r_re;
        w_mul_b = r_re;
        unique case (r_state)
            S_MII: begin
                w_mul_a = r_im;
                w_mul_b = r_im;
            end
            S_MRI: begin
                w_mul_a = r_re;
                w_mul_b = r_im;
            end
            default: begin
                w_mul_a = r_re;
                w_mul_b = r_re;
            end
        endcase
    end

    assign w_mag    = PROD_W'(unsigned'(r_sq_re)) + PROD_W'(unsigned'(r_sq_im));
    assign w_escape = (r_count != '0) && (w_mag > ESCAPE_LIMIT);
    assign w_nre    = EXT_W'(r_diff >>> FRAC_BITS) + EXT_W'(i_c_real);
    assign w_nim    = EXT_W'(r_cross >>> (FRAC_BITS - 1)) + EXT_W'(i_c_imag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_re    <= i_point.start_real;
                        r_im    <= i_point.start_imag;
                        r_count <= '0;
                        r_state <= S_MRR;
                    end
                end
                S_MRR: begin
                    r_state <= S_MII;
                end
                S_MII: begin
                    r_sq_re <= w_prod;
                    r_state <= S_MRI;
                end
                S_MRI: begin
                    r_sq_im <= w_prod;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_cross <= w_prod;
                    r_diff  <= r_sq_re - r_sq_im;
                    if (w_escape || r_count == CNT_MAX) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_re    <= sat32(w_nre);
                    r_im    <= sat32(w_nim);
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_MRR;
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_cnt_ext = (CNT_W + COUNT_W)'(r_count);

    assign o_status.busy            = (r_state != S_IDLE);
    assign o_status.done            = (r_state == S_DONE);
    assign o_result.iteration_count = w_cnt_ext[COUNT_W-1:0];
    assign o_result.inside_set      = (r_count == CNT_MAX);

endmodule : jet_engine
`default_nettype wire

@@ rtl/core/julia_escape_time_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// julia_escape_time_top
// Julia set escape-time iteration for one pixel per transaction.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | payload
//  ---------+----------------------------------------+-------------------------
//  input    | i_in_valid, o_in_stall, i_in_data      | t_in  (start point)
//  output   | o_out_valid, i_out_stall, o_out_data   | t_out (count, inside)
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data        | c_real, c_imag
//
//  An iteration steps through S_MRR, S_MII, S_MRI, S_CHK, S_UPD on the shared
//  32x32 multiplier (three products, a test, an update; the last stops at the
//  test). The result is registered; the next point is accepted once idle.
//  Reset is synchronous, active low; c resets to zero.
//  The input stalls while a point is in flight; a finished result waits in
//  the engine while the output register is held by a stalled transaction.
// ----------------------------------------------------------------------------
module julia_escape_time_top
    import jet_pkg::*;
#(
    parameter int MAX_ITERATIONS = MAX_ITER_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out                      o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    logic signed [DATA_W-1:0] r_c_real;
    logic signed [DATA_W-1:0] r_c_imag;
    logic                     r_out_valid;
    t_out                     r_out_data;

    t_eng_status w_status;
    t_out        w_result;
    logic        w_start;
    logic        w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real <= '0;
            r_c_imag <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_C_REAL: r_c_real <= i_cfg_data;
                CFG_C_IMAG: r_c_imag <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = w_status.busy;
    assign w_start    = i_in_valid && !w_status.busy;
    assign w_take     = w_status.done && (!r_out_valid || !i_out_stall);

    jet_engine #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_point  (i_in_data),
        .i_c_real (r_c_real),
        .i_c_imag (r_c_imag),
        .i_take   (w_take),
        .o_status (w_status),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
            r_out_data  <= w_result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a point");

    a_inside_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.inside_set) |->
            (o_out_data.iteration_count == COUNT_W'(MAX_ITERATIONS)))
        else $error("inside flag set with a count below the limit");

    a_load_from_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_status.done))
        else $error("output loaded without a finished point");

endmodule : julia_escape_time_top
`default_nettype wire
